// ----- hdl/message_ring_queue_overwrite_oldest_macros.svh -----
// ----------------------------------------------------------------------------
// message ring queue assertion macros
// concurrent checks clocked on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef MESSAGE_RING_QUEUE_OVERWRITE_OLDEST_MACROS_SVH
`define MESSAGE_RING_QUEUE_OVERWRITE_OLDEST_MACROS_SVH

// same-cycle implication
`define MRQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MRQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mrq_pkg.sv -----
// ----------------------------------------------------------------------------
// mrq_pkg
// shared types and constants of the message ring queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrq_pkg;

  localparam int DATA_W     = 8;
  localparam int IDX_W      = 8;
  localparam int HEAD_LEN_W = 9;
  localparam int TAIL_W     = 3;
  localparam int S_TDATA_W  = 16;
  localparam int S_TUSER_W  = 2;
  localparam int M_TDATA_W  = 24;
  localparam int M_TUSER_W  = 2;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_DROP  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_OVERWRITE = 2'd3
  } status_t;

  typedef struct packed {
    req_type_t          req_type;
    logic [DATA_W-1:0]  data_byte;
    logic               last_byte;
    logic [IDX_W-1:0]   byte_index;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0]     read_byte;
    logic [HEAD_LEN_W-1:0] head_length;
    status_t               status;
    logic                  is_empty;
    logic                  is_full;
    logic [TAIL_W-1:0]     tail_slot;
  } res_t;

  // memory strobes from the sequencer to the store
  typedef struct packed {
    logic byte_we;
    logic byte_re;
    logic len_we;
    logic len_re;
  } mem_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/message_ring_queue_overwrite_oldest.sv -----
// ----------------------------------------------------------------------------
// message_ring_queue_overwrite_oldest
// ring of message slots with a sentinel slot, oldest message overwritten
// ----------------------------------------------------------------------------
// usage
//   s_* carries one request item: s_tuser picks write byte, read head byte,
//   drop head or nothing; s_tlast marks the last byte of a written message.
//   m_* returns exactly one result item per request: read byte, head length,
//   empty, full and tail slot in m_tdata, status code in m_tuser.
// sequencing
//   an accepted request passes through the BUSY state, where the registered
//   read of the byte and length memories lands, before its result is loaded
//   into the output register; no new request is taken while BUSY
// reset
//   rst empties the queue (pointers and write count to zero); memory contents
//   are not cleared, only committed slots are ever read
// back pressure
//   a result waits in the output register while m_tready is low; s_tready
//   stays low until that register is free or being emptied
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module message_ring_queue_overwrite_oldest
  import mrq_pkg::*;
#(
  parameter int SLOTS     = 8,
  parameter int MSG_BYTES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // data_byte[7:0], byte_index[15:8]
  input  wire logic [S_TUSER_W-1:0] s_tuser,  // req_type[1:0]
  input  wire logic                 s_tlast,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // read_byte[7:0], head_length[16:8], is_empty[17], is_full[18],
  // tail_slot[21:19], zero pad[23:22]
  output logic      [M_TDATA_W-1:0] m_tdata,
  output logic      [M_TUSER_W-1:0] m_tuser   // status[1:0]
);

  localparam int PTR_W = $clog2(SLOTS);
  localparam int OFF_W = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int CNT_W = $clog2(MSG_BYTES + 1);
  localparam int PAD_W = M_TDATA_W - DATA_W - HEAD_LEN_W - 2 - TAIL_W;

  req_t              in_req;
  res_t              res;
  logic              res_valid;
  logic              out_free;
  mem_cmd_t          mem_cmd;
  logic [PTR_W-1:0]  byte_slot;
  logic [OFF_W-1:0]  byte_off;
  logic [DATA_W-1:0] byte_wdata;
  logic [DATA_W-1:0] byte_rdata;
  logic [PTR_W-1:0]  len_waddr;
  logic [CNT_W-1:0]  len_wdata;
  logic [PTR_W-1:0]  len_raddr;
  logic [CNT_W-1:0]  len_rdata;

  // unpack the request item
  always_comb begin
    in_req.req_type   = req_type_t'(s_tuser);
    in_req.data_byte  = s_tdata[DATA_W-1:0];
    in_req.last_byte  = s_tlast;
    in_req.byte_index = s_tdata[DATA_W +: IDX_W];
  end

  // output register empties this cycle or already is empty
  assign out_free = !m_tvalid || m_tready;

  mrq_ctrl #(
    .SLOTS     (SLOTS),
    .MSG_BYTES (MSG_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_req     (in_req),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .res        (res),
    .mem_cmd    (mem_cmd),
    .byte_slot  (byte_slot),
    .byte_off   (byte_off),
    .byte_wdata (byte_wdata),
    .byte_rdata (byte_rdata),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata),
    .len_raddr  (len_raddr),
    .len_rdata  (len_rdata)
  );

  mrq_store #(
    .SLOTS     (SLOTS),
    .MSG_BYTES (MSG_BYTES)
  ) u_store (
    .clk        (clk),
    .mem_cmd    (mem_cmd),
    .byte_slot  (byte_slot),
    .byte_off   (byte_off),
    .byte_wdata (byte_wdata),
    .byte_rdata (byte_rdata),
    .len_waddr  (len_waddr),
    .len_wdata  (len_wdata),
    .len_raddr  (len_raddr),
    .len_rdata  (len_rdata)
  );

  // result register, loaded only when it is free
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {{PAD_W{1'b0}}, res.tail_slot, res.is_full, res.is_empty,
                  res.head_length, res.read_byte};
      m_tuser <= M_TUSER_W'(res.status);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mrq_store.sv -----
// ----------------------------------------------------------------------------
// mrq_store
// message byte memory and slot length memory, both with registered reads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrq_store
  import mrq_pkg::*;
#(
  parameter int SLOTS     = 8,
  parameter int MSG_BYTES = 256,
  localparam int PTR_W    = $clog2(SLOTS),
  localparam int OFF_W    = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1,
  localparam int CNT_W    = $clog2(MSG_BYTES + 1)
) (
  input  wire logic              clk,
  input  wire mem_cmd_t          mem_cmd,
  input  wire logic [PTR_W-1:0]  byte_slot,
  input  wire logic [OFF_W-1:0]  byte_off,
  input  wire logic [DATA_W-1:0] byte_wdata,
  output logic      [DATA_W-1:0] byte_rdata,
  input  wire logic [PTR_W-1:0]  len_waddr,
  input  wire logic [CNT_W-1:0]  len_wdata,
  input  wire logic [PTR_W-1:0]  len_raddr,
  output logic      [CNT_W-1:0]  len_rdata
);

  localparam int DEPTH  = SLOTS * MSG_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [DATA_W-1:0] bytes_mem [DEPTH];
  logic [CNT_W-1:0]  len_mem   [SLOTS];
  logic [ADDR_W-1:0] byte_addr;

  // slot base plus offset
  assign byte_addr = ADDR_W'(byte_slot) * ADDR_W'(MSG_BYTES) + ADDR_W'(byte_off);

  always_ff @(posedge clk) begin
    if (mem_cmd.byte_we) begin
      bytes_mem[byte_addr] <= byte_wdata;
    end
    if (mem_cmd.byte_re) begin
      byte_rdata <= bytes_mem[byte_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_cmd.len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (mem_cmd.len_re) begin
      len_rdata <= len_mem[len_raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/mrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrq_ctrl
// ring pointers, write assembly and request sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "message_ring_queue_overwrite_oldest_macros.svh"

module mrq_ctrl
  import mrq_pkg::*;
#(
  parameter int SLOTS     = 8,
  parameter int MSG_BYTES = 256,
  localparam int PTR_W    = $clog2(SLOTS),
  localparam int OFF_W    = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1,
  localparam int CNT_W    = $clog2(MSG_BYTES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire req_t              in_req,
  input  wire logic              out_free,
  output logic                   res_valid,
  output res_t                   res,
  output mem_cmd_t               mem_cmd,
  output logic      [PTR_W-1:0]  byte_slot,
  output logic      [OFF_W-1:0]  byte_off,
  output logic      [DATA_W-1:0] byte_wdata,
  input  wire logic [DATA_W-1:0] byte_rdata,
  output logic      [PTR_W-1:0]  len_waddr,
  output logic      [CNT_W-1:0]  len_wdata,
  output logic      [PTR_W-1:0]  len_raddr,
  input  wire logic [CNT_W-1:0]  len_rdata
);

  localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

  typedef enum logic {IDLE, BUSY} state_t;

  state_t           state;
  logic [PTR_W-1:0] head, head_next;
  logic [PTR_W-1:0] tail, tail_next;
  logic [CNT_W-1:0] cnt, cnt_next, cnt_cmt;
  logic             ovf, ovf_next, ovf_cmt;
  logic [CNT_W-1:0] head_len, head_len_next;
  logic             rd_pend, rd_pend_next;
  logic             len_pend, len_pend_next;
  status_t          status_q, status_next;

  logic             fire;
  logic             empty_now, full_now;
  logic [PTR_W-1:0] wslot, hslot;
  logic [CNT_W-1:0] cur_len;

  function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready  = (state == IDLE) && out_free;
  assign fire      = in_valid && in_ready;
  assign empty_now = (head == tail);
  assign full_now  = (nxt(tail) == head);
  assign wslot     = nxt(tail);
  assign hslot     = nxt(head);
  assign byte_wdata = in_req.data_byte;

  always_comb begin
    head_next     = head;
    tail_next     = tail;
    cnt_next      = cnt;
    ovf_next      = ovf;
    cnt_cmt       = cnt;
    ovf_cmt       = ovf;
    head_len_next = head_len;
    rd_pend_next  = 1'b0;
    len_pend_next = 1'b0;
    status_next   = ST_OK;
    mem_cmd       = '0;
    byte_slot     = wslot;
    byte_off      = OFF_W'(cnt);
    len_waddr     = wslot;
    len_raddr     = nxt(hslot);

    // refreshed head length lands while busy
    if (state == BUSY && len_pend) begin
      head_len_next = len_rdata;
    end

    if (fire) begin
      case (in_req.req_type)
        REQ_WRITE: begin
          if (cnt < CNT_W'(MSG_BYTES)) begin
            mem_cmd.byte_we = 1'b1;
            cnt_cmt         = cnt + 1'b1;
          end else begin
            ovf_cmt = 1'b1;
          end
          if (in_req.last_byte) begin
            if (ovf_cmt) begin
              status_next = ST_TOO_LONG;
            end else begin
              mem_cmd.len_we = 1'b1;
              tail_next      = wslot;
              if (full_now) begin
                head_next   = hslot;
                status_next = ST_OVERWRITE;
                // new head may be the slot committed right now
                if (nxt(hslot) == wslot) begin
                  head_len_next = cnt_cmt;
                end else begin
                  mem_cmd.len_re = 1'b1;
                  len_pend_next  = 1'b1;
                end
              end else if (empty_now) begin
                head_len_next = cnt_cmt;
              end
            end
            cnt_next = '0;
            ovf_next = 1'b0;
          end else begin
            cnt_next = cnt_cmt;
            ovf_next = ovf_cmt;
          end
        end
        REQ_READ: begin
          if (empty_now) begin
            status_next = ST_EMPTY;
          end else begin
            byte_slot = hslot;
            byte_off  = OFF_W'(in_req.byte_index);
            if (CMP_W'(in_req.byte_index) < CMP_W'(head_len) &&
                CMP_W'(in_req.byte_index) < CMP_W'(MSG_BYTES)) begin
              mem_cmd.byte_re = 1'b1;
              rd_pend_next    = 1'b1;
            end
          end
        end
        REQ_DROP: begin
          if (empty_now) begin
            status_next = ST_EMPTY;
          end else begin
            head_next = hslot;
            if (hslot != tail) begin
              mem_cmd.len_re = 1'b1;
              len_pend_next  = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    len_wdata = cnt_cmt;
  end

  // result is formed from the already updated pointers
  assign cur_len   = len_pend ? len_rdata : head_len;
  assign res_valid = (state == BUSY);

  always_comb begin
    res.read_byte   = rd_pend ? byte_rdata : '0;
    res.head_length = empty_now ? '0 : HEAD_LEN_W'(cur_len);
    res.status      = status_q;
    res.is_empty    = empty_now;
    res.is_full     = full_now;
    res.tail_slot   = TAIL_W'(tail);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      head     <= '0;
      tail     <= '0;
      cnt      <= '0;
      ovf      <= 1'b0;
      rd_pend  <= 1'b0;
      len_pend <= 1'b0;
    end else begin
      case (state)
        IDLE:    state <= fire ? BUSY : IDLE;
        BUSY:    state <= IDLE;
        default: state <= IDLE;
      endcase
      head     <= head_next;
      tail     <= tail_next;
      cnt      <= cnt_next;
      ovf      <= ovf_next;
      rd_pend  <= rd_pend_next;
      len_pend <= len_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    head_len <= head_len_next;
    if (fire) begin
      status_q <= status_next;
    end
  end

  `MRQ_ASSERT_NEXT(a_fire_gives_result, fire, res_valid, "accepted item gave no result")
  `MRQ_ASSERT(a_ovf_only_when_full_slot, ovf, cnt == CNT_W'(MSG_BYTES), "overflow below slot size")
  `MRQ_ASSERT_NEXT(a_read_keeps_ptrs, fire && in_req.req_type == REQ_READ, (head == $past(head)) && (tail == $past(tail)), "read moved a pointer")
  `MRQ_ASSERT(a_one_byte_access, 1'b1, !(mem_cmd.byte_we && mem_cmd.byte_re), "byte memory read and write together")

endmodule

`default_nettype wire
